// ===== sv/plti_pkg.sv =====
// Shared types and constants for the piecewise-linear table interpolator.
// No dependencies.
package plti_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 48;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int REM_W      = DIFF_W + 1;
  localparam int STEP_W     = $clog2(PROD_W + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [DIFF_W-1:0]        mag_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic start;
  } md_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

// ===== sv/piecewise_linear_table_interp.sv =====
// Piecewise-linear lookup table with interpolation.
//
// Input channel (in_valid / in_stall): each item either loads one breakpoint
// (in_req_type low: in_point_index, in_point_x, in_point_y) or queries the
// table at in_query_x. A load gives no result; a query gives one item on the
// output channel (out_valid / out_stall) carrying out_result_y.
// The breakpoints sit in a ring of cells. A query rotates the ring once, one
// entry per cycle, to find the clamp values and the first bracketing segment.
// A serial multiplier and a restoring divider then form the slope term; a
// query that clamps skips them. A load is written straight into its cell.
// One item is worked on at a time: in_stall is high from acceptance of a
// query until its result has entered the output register.
// If the receiver stalls, the result holds in the output register; the block
// still takes the next item, and a following query holds its finished result
// with in_stall high until the output register is free.
// cfg_wr_en writes num_points from cfg_wr_data; the user must do so only while
// the block is idle; the block does not enforce this. Synchronous reset clears
// the control state and num_points; the table contents are undefined until loaded,
// and entry 0 must be loaded first. Depends on plti_pkg, plti_cell and plti_muldiv.
module piecewise_linear_table_interp import plti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [IDX_W-1:0]  in_point_index,
  input  data_t             in_point_x,
  input  data_t             in_point_y,
  input  data_t             in_query_x,
  output logic              out_valid,
  input  logic              out_stall,
  output data_t             out_result_y,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DEC, S_WAIT, S_FIN} state_t;

  state_t            state_r;
  logic [6:0]        num_r;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  k_r;
  data_t             qx_r, y0_r, ylast_r, xi_r, yi_r, xi1_r, yi1_r, res_r;
  logic              le0_r, gelast_r, found_r, neg_r;
  mag_t              ma_r, mb_r, md_r, q;
  md_ctl_t           md_ctl;
  md_stat_t          md_stat;
  logic              out_valid_r;
  data_t             out_y_r;

  data_t cx [MAX_POINTS];
  data_t cy [MAX_POINTS];

  logic accept, load_en, rot_en, bracket, in_seg;
  diff_t dx, dy, dq;
  logic signed [DATA_W+1:0] sum;

  assign accept  = in_valid && !in_stall;
  assign load_en = accept && (in_req_type == REQ_LOAD);
  assign rot_en  = (state_r == S_SCAN);

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    plti_cell u_cell (
      .clk      (clk),
      .shift_en (rot_en),
      .sh_x     (cx[(i + 1) % MAX_POINTS]),
      .sh_y     (cy[(i + 1) % MAX_POINTS]),
      .wr_en    (load_en && (in_point_index == IDX_W'(i))),
      .wr_x     (in_point_x),
      .wr_y     (in_point_y),
      .x        (cx[i]),
      .y        (cy[i])
    );
  end

  assign n_eff = (num_r > 7'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(num_r);

  // Cell 0 holds entry k and cell 1 entry k+1 during scan step k.
  assign bracket = ((qx_r >= cx[0]) && (qx_r < cx[1])) ||
                   ((qx_r <= cx[0]) && (qx_r > cx[1]));
  assign in_seg  = ((k_r + 1'b1) < n_eff);

  assign dx = diff_t'(xi1_r) - diff_t'(xi_r);
  assign dy = diff_t'(yi1_r) - diff_t'(yi_r);
  assign dq = diff_t'(qx_r) - diff_t'(xi_r);

  // The operand registers are loaded in S_DEC, so the multiply-divide unit is started in the next cycle, from S_WAIT.
  assign md_ctl.start = (state_r == S_WAIT) && !md_stat.busy;

  plti_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (md_ctl),
    .a     (ma_r),
    .b     (mb_r),
    .d     (md_r),
    .stat  (md_stat),
    .q     (q)
  );

  assign sum = neg_r ? ((DATA_W+2)'(yi_r) - (DATA_W+2)'({1'b0, q}))
                     : ((DATA_W+2)'(yi_r) + (DATA_W+2)'({1'b0, q}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_r       <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (cfg_wr_en) num_r <= cfg_wr_data;
      if (out_valid_r && !out_stall && (state_r != S_FIN)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_req_type == REQ_QUERY)) begin
            qx_r    <= in_query_x;
            k_r     <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (k_r == '0) begin
            y0_r  <= cy[0];
            le0_r <= (qx_r <= cx[0]);
          end
          if ((n_eff != '0) && (k_r == n_eff - 1'b1)) begin
            ylast_r  <= cy[0];
            gelast_r <= (qx_r >= cx[0]);
          end
          if (!found_r && in_seg && bracket) begin
            found_r <= 1'b1;
            xi_r    <= cx[0];
            yi_r    <= cy[0];
            xi1_r   <= cx[1];
            yi1_r   <= cy[1];
          end
          // A full turn leaves every entry back in its own cell.
          if (k_r == CNT_W'(MAX_POINTS - 1)) state_r <= S_DEC;
          k_r <= k_r + 1'b1;
        end
        S_DEC: begin
          ma_r  <= dy[DIFF_W-1] ? mag_t'(-dy) : mag_t'(dy);
          mb_r  <= dq[DIFF_W-1] ? mag_t'(-dq) : mag_t'(dq);
          md_r  <= dx[DIFF_W-1] ? mag_t'(-dx) : mag_t'(dx);
          neg_r <= dy[DIFF_W-1] ^ dq[DIFF_W-1] ^ dx[DIFF_W-1];
          priority if (le0_r) begin
            res_r   <= y0_r;
            state_r <= S_FIN;
          end else if (n_eff == '0) begin
            res_r   <= '0;
            state_r <= S_FIN;
          end else if (gelast_r || !found_r) begin
            res_r   <= ylast_r;
            state_r <= S_FIN;
          end else if (dx == '0) begin
            res_r   <= yi_r;
            state_r <= S_FIN;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (md_stat.done) begin
            if (sum > $signed({2'b00, 1'b0, {(DATA_W-1){1'b1}}}))
              res_r <= {1'b0, {(DATA_W-1){1'b1}}};
            else if (sum < $signed({2'b11, 1'b1, {(DATA_W-1){1'b0}}}))
              res_r <= {1'b1, {(DATA_W-1){1'b0}}};
            else
              res_r <= sum[DATA_W-1:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_y_r     <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_result_y = out_y_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_stat.done |-> (state_r == S_WAIT))
    else $error("divider finished outside the wait state");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    md_ctl.start |-> !md_stat.busy)
    else $error("divider started while busy");

  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r < CNT_W'(MAX_POINTS)))
    else $error("scan ran past the table");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("finished item not presented");

endmodule

// ===== sv/plti_cell.sv =====
// One breakpoint cell of the table ring: holds an (x, y) pair.
// Depends on plti_pkg.
module plti_cell import plti_pkg::*; (
  input  logic  clk,
  input  logic  shift_en,
  input  data_t sh_x,
  input  data_t sh_y,
  input  logic  wr_en,
  input  data_t wr_x,
  input  data_t wr_y,
  output data_t x,
  output data_t y
);

  data_t x_r, y_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      x_r <= sh_x;
      y_r <= sh_y;
    end else if (wr_en) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

// ===== sv/plti_muldiv.sv =====
// Serial unsigned multiply then restoring divide: q = (a * b) / d.
// One bit per cycle for each phase. Depends on plti_pkg.
module plti_muldiv import plti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  md_ctl_t  ctl,
  input  mag_t     a,
  input  mag_t     b,
  input  mag_t     d,
  output md_stat_t stat,
  output mag_t     q
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_DONE} mstate_t;

  mstate_t             state_r;
  logic [STEP_W-1:0]   step_r;
  logic [PROD_W-1:0]   prod_r;
  logic [REM_W-1:0]    rem_r;
  mag_t                a_r, b_r, d_r, q_r;
  logic [REM_W-1:0]    rem_sh;
  logic [PROD_W-1:0]   addend;

  assign rem_sh = {rem_r[REM_W-2:0], prod_r[PROD_W-1]};
  assign addend = b_r[step_r[$clog2(DIFF_W)-1:0]] ? {{DIFF_W{1'b0}}, a_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        M_IDLE: begin
          if (ctl.start) begin
            a_r     <= a;
            b_r     <= b;
            d_r     <= d;
            prod_r  <= '0;
            step_r  <= STEP_W'(DIFF_W - 1);
            state_r <= M_MUL;
          end
        end
        M_MUL: begin
          // Most significant multiplier bit first.
          prod_r <= {prod_r[PROD_W-2:0], 1'b0} + addend;
          if (step_r == '0) begin
            step_r  <= STEP_W'(PROD_W - 1);
            rem_r   <= '0;
            q_r     <= '0;
            state_r <= M_DIV;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        M_DIV: begin
          prod_r <= {prod_r[PROD_W-2:0], 1'b0};
          if (rem_sh >= {1'b0, d_r}) begin
            rem_r <= rem_sh - {1'b0, d_r};
            q_r   <= {q_r[DIFF_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[DIFF_W-2:0], 1'b0};
          end
          if (step_r == '0) state_r <= M_DONE;
          else step_r <= step_r - 1'b1;
        end
        M_DONE: state_r <= M_IDLE;
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != M_IDLE);
  assign stat.done = (state_r == M_DONE);
  assign q = q_r;

endmodule

// ===== verif/tb_piecewise_linear_table_interp.sv =====
// Self-checking testbench for piecewise_linear_table_interp: loads and queries the table
// through both handshakes and checks every result against a scoreboard that models the table.
// Depends on plti_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interp;
  import plti_pkg::*;

  localparam int  HOLD_CYCLES  = 1500;
  localparam int  SETTLE       = 300;
  localparam longint LIMIT     = 4000000;

  class interp_scoreboard;
    data_t        tab_x [MAX_POINTS];
    data_t        tab_y [MAX_POINTS];
    logic [6:0]   count;
    data_t        pending_y [$];
    int           errors;

    function new();
      count  = '0;
      errors = 0;
      foreach (tab_x[k]) begin
        tab_x[k] = '0;
        tab_y[k] = '0;
      end
    endfunction

    function data_t interp_at(data_t qx);
      int                n;
      int                i;
      bit                found;
      logic signed [49:0] a, b, dx, dy, dq;
      logic [63:0]       mx, my, mq;
      logic [127:0]      prod, quo;
      logic              neg;
      logic signed [52:0] res;
      n = (count > MAX_POINTS) ? MAX_POINTS : count;
      if (qx <= tab_x[0]) return tab_y[0];
      if (n == 0) return '0;
      if (qx >= tab_x[n-1]) return tab_y[n-1];
      found = 0;
      for (i = 0; i + 1 < n; i++) begin
        if ((qx >= tab_x[i] && qx < tab_x[i+1]) || (qx <= tab_x[i] && qx > tab_x[i+1])) begin
          found = 1;
          break;
        end
      end
      if (!found) return tab_y[n-1];
      a = tab_x[i+1]; b = tab_x[i]; dx = a - b;
      a = tab_y[i+1]; b = tab_y[i]; dy = a - b;
      a = qx;         b = tab_x[i]; dq = a - b;
      if (dx == 0) return tab_y[i];
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      mq = (dq < 0) ? -dq : dq;
      prod = {64'd0, my} * {64'd0, mq};
      quo  = prod / {64'd0, mx};
      if (quo > (128'd1 << 50)) quo = 128'd1 << 50;
      neg = ((dy < 0) != (dq < 0)) != (dx < 0);
      if (dy == 0 || dq == 0) neg = 1'b0;
      res = tab_y[i];
      res = neg ? res - $signed({1'b0, quo[51:0]}) : res + $signed({1'b0, quo[51:0]});
      if (res > $signed(53'h7FFFFFFFFFFF)) res = 53'h7FFFFFFFFFFF;
      if (res < -$signed(53'h800000000000)) res = -$signed(53'h800000000000);
      return res[47:0];
    endfunction

    function void set_count(logic [6:0] value);
      count = value;
    endfunction

    function void note_input(logic req, logic [IDX_W-1:0] idx, data_t px, data_t py,
                             data_t qx);
      if (req == REQ_LOAD) begin
        tab_x[idx] = px;
        tab_y[idx] = py;
      end else begin
        pending_y.push_back(interp_at(qx));
      end
    endfunction

    function void check_result(data_t got);
      data_t want;
      if (pending_y.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_y.pop_front();
      if (got !== want) begin
        $display("%0t: result_y mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_req_type;
  logic [IDX_W-1:0]  in_point_index;
  data_t             in_point_x;
  data_t             in_point_y;
  data_t             in_query_x;
  logic              out_valid;
  logic              out_stall;
  data_t             out_result_y;
  logic              cfg_wr_en;
  logic [6:0]        cfg_wr_data;

  interp_scoreboard  sb;
  bit                written [MAX_POINTS];
  data_t             plan_x [MAX_POINTS];
  data_t             plan_y [MAX_POINTS];
  bit                calm;
  bit                hold_req;

  piecewise_linear_table_interp u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_point_index (in_point_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_query_x     (in_query_x),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_y   (out_result_y),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic data_t rand48();
    return data_t'({$urandom(), $urandom()});
  endfunction

  // Offers one item and returns at the edge that accepts it; then, unless calm is set, idles for a random gap.
  task automatic send_item(logic req, logic [IDX_W-1:0] idx, data_t px, data_t py,
                           data_t qx);
    int  gap;
    bit  take;
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_point_index <= idx;
    in_point_x     <= px;
    in_point_y     <= py;
    in_query_x     <= qx;
    do begin
      @(negedge clk);
      take = !in_stall;
      @(posedge clk);
    end while (!take);
    sb.note_input(req, idx, px, py, qx);
    if (req == REQ_LOAD) written[idx] = 1;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load(int idx, data_t px, data_t py);
    send_item(REQ_LOAD, idx[IDX_W-1:0], px, py, rand48());
  endtask

  task automatic query(data_t qx);
    send_item(REQ_QUERY, IDX_W'($urandom()), rand48(), rand48(), qx);
  endtask

  // The count register is only touched once the block has drained.
  task automatic write_count(logic [6:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_y.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_count(value);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic make_plan();
    data_t step;
    int    k;
    int    sh;
    if ($urandom_range(0, 4) == 0) begin
      foreach (plan_x[k]) begin
        plan_x[k] = rand48();
        plan_y[k] = rand48();
      end
    end else begin
      sh = $urandom_range(0, 40);
      plan_x[0] = $signed(rand48()) >>> 2;
      for (k = 0; k < MAX_POINTS; k++) begin
        if (k > 0) begin
          step = data_t'(({$urandom(), $urandom()} & ((64'd1 << sh) - 1)) + 1);
          plan_x[k] = plan_x[k-1] + step;
        end
        plan_y[k] = ($urandom_range(0, 1) != 0) ? rand48()
                                                : data_t'($signed($urandom()) >>> 8);
      end
    end
  endtask

  function automatic data_t pick_query(int n);
    int    k;
    data_t lo, hi, span;
    k = (n > 1) ? $urandom_range(0, n - 2) : 0;
    case ($urandom_range(0, 4))
      0: return sb.tab_x[$urandom_range(0, (n > 0) ? n - 1 : 0)];
      1: return rand48();
      default: begin
        lo = sb.tab_x[k];
        hi = (n > 1) ? sb.tab_x[k+1] : sb.tab_x[0];
        if (hi < lo) begin
          span = lo; lo = hi; hi = span;
        end
        span = hi - lo;
        if (span <= 0) return lo;
        return lo + data_t'({$urandom(), $urandom()} % span);
      end
    endcase
  endfunction

  task automatic random_items(int items);
    int  n;
    int  j;
    int  need;
    int  k;
    n = (sb.count > MAX_POINTS) ? MAX_POINTS : sb.count;
    for (j = 0; j < items; j++) begin
      need = -1;
      for (k = 0; k < ((n > 0) ? n : 1); k++) begin
        if (!written[k] && need < 0) need = k;
      end
      if (need >= 0) begin
        load(need, plan_x[need], plan_y[need]);
      end else if ($urandom_range(0, 99) < 30) begin
        k = $urandom_range(0, MAX_POINTS - 1);
        if ($urandom_range(0, 19) == 0) load(k, rand48(), rand48());
        else load(k, plan_x[k], plan_y[k]);
      end else begin
        query(pick_query(n));
      end
    end
  endtask

  initial begin
    int          ph;
    logic [6:0]  cnt;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_LOAD;
    in_point_index = '0;
    in_point_x     = '0;
    in_point_y     = '0;
    in_query_x     = '0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    foreach (written[k]) written[k] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With a count of zero only entry 0 matters: at or below x0 it answers y0, above it 0.
    load(0, '0, 48'sh0000_0005_0000);
    query(48'sh800000000000);
    query(48'sh7FFFFFFFFFFF);
    query('0);
    write_count(7'd2);
    load(1, 48'sh0000_0064_0000, -48'sh0000_0003_8000);
    query(48'sh0000_0021_1234);
    query(48'sh0000_0064_0000);
    query(48'sh7FFFFFFFFFFF);
    query(-48'sh0000_0000_0001);
    write_count(7'd4);
    load(2, 48'sh0000_0032_0000, 48'sh7FFFFFFFFFFF);
    load(3, 48'sh0000_00C8_0000, 48'sh800000000000);
    query(48'sh0000_0070_0000);
    query(48'sh0000_0033_0001);
    query(48'sh0000_00C7_FFFF);
    load(4, 48'sh800000000000, 48'sh7FFFFFFFFFFF);
    load(5, 48'sh7FFFFFFFFFFF, 48'sh800000000000);
    write_count(7'd6);
    query(48'sh0000_0070_0000);

    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: cnt = 7'd64;
        1: cnt = 7'd0;
        2: cnt = 7'd1;
        3: cnt = 7'd127;
        4: cnt = 7'd2;
        default: cnt = $urandom_range(3, 100);
      endcase
      make_plan();
      write_count(cnt);
      calm     = ($urandom_range(0, 3) == 0);
      hold_req = (ph == 2 || ph == 6);
      random_items(185);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_y.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int    hold;
    bit    got;
    data_t y;
    @(posedge rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 16);
      if (hold_req) begin
        // A long hold-off while the sender keeps offering items.
        hold     = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = out_valid;
        y   = out_result_y;
        @(posedge clk);
      end while (!got);
      sb.check_result(y);
    end
  end

endmodule
